// ===== hw/rtl/peu_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle update package
// Shared constants, state encoding and fixed-point helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package peu_pkg;

	localparam int NUM_FRAMES = 4;
	localparam logic [31:0] ANIM_PERIOD = 32'd6554;

	// Progress width (Q0.16) and shared multiplier operand widths.
	localparam int T_W  = 16;
	localparam int MA_W = 34;
	localparam int MB_W = 18;
	localparam int MP_W = 52;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_SPAWN = 1'b1;

	localparam logic [2:0] REG_GRAVITY_X   = 3'd0;
	localparam logic [2:0] REG_GRAVITY_Y   = 3'd1;
	localparam logic [2:0] REG_LIFE_SPAN   = 3'd2;
	localparam logic [2:0] REG_ALPHA_BEGIN = 3'd3;
	localparam logic [2:0] REG_ALPHA_FINAL = 3'd4;
	localparam logic [2:0] REG_SIZE_BEGIN  = 3'd5;
	localparam logic [2:0] REG_SIZE_FINAL  = 3'd6;
	localparam logic [2:0] REG_EASING_MODE = 3'd7;

	localparam logic [2:0] EASE_NONE        = 3'd0;
	localparam logic [2:0] EASE_QUAD_IN     = 3'd1;
	localparam logic [2:0] EASE_QUAD_OUT    = 3'd2;
	localparam logic [2:0] EASE_QUAD_INOUT  = 3'd3;
	localparam logic [2:0] EASE_CUBIC_IN    = 3'd4;
	localparam logic [2:0] EASE_CUBIC_OUT   = 3'd5;
	localparam logic [2:0] EASE_CUBIC_INOUT = 3'd6;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_GVX,
		ST_GVY,
		ST_VELY,
		ST_DIV,
		ST_SQ,
		ST_CUBE,
		ST_EASE,
		ST_IVX,
		ST_IVY,
		ST_FVY,
		ST_PX,
		ST_PY,
		ST_POSY,
		ST_ALPHA,
		ST_SIZE,
		ST_DONE
	} st_t;

	// Unsigned add of a Q0.16 step onto a 32-bit accumulator, clamped at all ones.
	function automatic logic [31:0] usat_add(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Round a Q.16 product half up, add it to a base and clamp to 32-bit signed.
	function automatic logic signed [31:0] sat_acc(input logic signed [31:0] base,
		input logic signed [MP_W-1:0] prod);
		logic signed [MP_W-1:0] r;
		logic signed [MP_W:0] s;
		r = (prod + $signed(52'd32768)) >>> 16;
		s = (MP_W+1)'(base) + (MP_W+1)'(r);
		if (s > $signed(53'd2147483647))
			return 32'sh7FFF_FFFF;
		else if (s < -$signed(53'd2147483648))
			return 32'sh8000_0000;
		else
			return s[31:0];
	endfunction

	// Final rounding and complement of the easing curve from the raw power.
	function automatic logic [16:0] ease_fin(input logic [MP_W-1:0] p,
		input logic [2:0] mode, input logic low);
		logic [MP_W-1:0] r;
		logic flip;
		r = '0;
		flip = 1'b0;
		case (mode)
			EASE_QUAD_IN: r = (p + 52'd32768) >> 16;
			EASE_QUAD_OUT: begin
				r = (p + 52'd32768) >> 16;
				flip = 1'b1;
			end
			EASE_QUAD_INOUT: begin
				if (low) begin
					r = ((p << 1) + 52'd32768) >> 16;
				end else begin
					r = (p + 52'd65536) >> 17;
					flip = 1'b1;
				end
			end
			EASE_CUBIC_IN: r = (p + 52'h8000_0000) >> 32;
			EASE_CUBIC_OUT: begin
				r = (p + 52'h8000_0000) >> 32;
				flip = 1'b1;
			end
			EASE_CUBIC_INOUT: begin
				if (low) begin
					r = ((p << 2) + 52'h8000_0000) >> 32;
				end else begin
					r = (p + 52'h1_0000_0000) >> 33;
					flip = 1'b1;
				end
			end
			default: r = 52'd65536;
		endcase
		return flip ? (17'd65536 - r[16:0]) : r[16:0];
	endfunction

endpackage

// ===== hw/rtl/peu_div.sv =====
// ----------------------------------------------------------------------------
// Progress divider
// Restoring divider giving floor(num * 2^16 / den), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peu_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [31:0]              num,
	input  logic [31:0]              den,
	output logic                     done,
	output logic [peu_pkg::T_W-1:0]  quot
);
	import peu_pkg::*;

	localparam int CNT_W = $clog2(T_W);

	logic [31:0]      rem_q;
	logic [T_W-1:0]   quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [32:0]      rem2;
	logic             fits;

	// The numerator is below the divisor, so the remainder always fits 32 bits.
	assign rem2 = {rem_q, 1'b0};
	assign fits = rem2 >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quot_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= num;
			end else if (busy_q) begin
				rem_q  <= fits ? 32'(rem2 - {1'b0, den}) : rem2[31:0];
				quot_q <= {quot_q[T_W-2:0], fits};
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(T_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== hw/rtl/particle_euler_update_with_easing_core.sv =====
// ----------------------------------------------------------------------------
// Particle Euler update with easing core
// Spawn, expiring tick and idle tick go straight to the result state. An active
// tick runs the gravity update, the 16-step divider, the easing power when easing
// is on, the eased velocity, position and blends: up to ten passes through the one
// shared 34x18 multiplier. The next request is taken once the result is registered.
// Async reset: particle inactive, config at defaults, opacity and size at one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_euler_update_with_easing_core (
	input  logic               clk,
	input  logic               arst_n,
	// Input request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [15:0]        delta_time,
	input  logic signed [31:0] spawn_pos_x,
	input  logic signed [31:0] spawn_pos_y,
	input  logic signed [31:0] spawn_vel_x,
	input  logic signed [31:0] spawn_vel_y,
	// Result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               alive,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic [16:0]        alpha_level,
	output logic [23:0]        scale,
	output logic [2:0]         frame_index,
	// Configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import peu_pkg::*;

	// Configuration registers.
	logic signed [31:0] gx_q, gy_q;
	logic [31:0]        life_q;
	logic [16:0]        ab_q, af_q;
	logic [23:0]        sb_q, sf_q;
	logic [2:0]         mode_q;

	// Particle state.
	logic               active_q;
	logic [31:0]        age_q, timer_q;
	logic signed [31:0] velx_q, vely_q, ivx_q, ivy_q, posx_q, posy_q;
	logic [2:0]         frame_q;
	logic [16:0]        alpha_q;
	logic [23:0]        size_q;

	// Working registers of one tick.
	logic [15:0]            dt_q;
	logic [T_W-1:0]         t_q;
	logic [16:0]            e_q;
	logic signed [31:0]     fvx_q, fvy_q;
	logic signed [MP_W-1:0] prod_q;

	// Result register.
	logic               out_valid_q, alive_q;
	logic signed [31:0] opx_q, opy_q;
	logic [16:0]        oalpha_q;
	logic [23:0]        oscale_q;
	logic [2:0]         oframe_q;

	st_t st_q, st_nx;

	logic                   in_acc, out_free;
	logic [31:0]            age_nx, timer_nx;
	logic [2:0]             frame_nx;
	logic                   ease_on, cubic, low;
	logic [16:0]            base;
	logic signed [MA_W-1:0] ma;
	logic signed [MB_W-1:0] mb;
	logic signed [MP_W-1:0] mul_p, rnd_p;
	logic signed [17:0]     alpha_diff;
	logic signed [24:0]     size_diff;
	logic                   div_start, div_done;
	logic [T_W-1:0]         div_quot;

	// A new request is taken only while the sequencer is idle; a finished result
	// may still wait in the output register at that time.
	assign in_stall  = (st_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign age_nx   = usat_add(age_q, delta_time);
	assign timer_nx = usat_add(timer_q, delta_time);
	assign frame_nx = (frame_q == 3'(NUM_FRAMES - 1)) ? 3'd0 : frame_q + 3'd1;

	assign ease_on = (mode_q != EASE_NONE) && (mode_q <= EASE_CUBIC_INOUT);
	assign cubic   = (mode_q == EASE_CUBIC_IN) || (mode_q == EASE_CUBIC_OUT)
		|| (mode_q == EASE_CUBIC_INOUT);
	// First half of an in-out curve: progress below one half.
	assign low     = !t_q[T_W-1];

	// Base of the easing power: t, 1 - t, or 2 - 2t for the second half of in-out.
	always_comb begin
		logic [17:0] w;
		w = 18'd131072 - {1'b0, t_q, 1'b0};
		case (mode_q)
			EASE_QUAD_OUT, EASE_CUBIC_OUT: base = 17'd65536 - {1'b0, t_q};
			EASE_QUAD_INOUT, EASE_CUBIC_INOUT: base = low ? {1'b0, t_q} : w[16:0];
			default: base = {1'b0, t_q};
		endcase
	end

	assign alpha_diff = $signed({1'b0, af_q}) - $signed({1'b0, ab_q});
	assign size_diff  = $signed({1'b0, sf_q}) - $signed({1'b0, sb_q});

	// Operand selection for the shared multiplier. Each multiplying state issues one product,
	// which the following state picks up from prod_q.
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			ST_GVX: begin
				ma = MA_W'(gx_q);
				mb = {2'b00, dt_q};
			end
			ST_GVY: begin
				ma = MA_W'(gy_q);
				mb = {2'b00, dt_q};
			end
			ST_SQ: begin
				ma = {17'd0, base};
				mb = {1'b0, base};
			end
			ST_CUBE: begin
				ma = prod_q[MA_W-1:0];
				mb = {1'b0, base};
			end
			ST_IVX: begin
				ma = MA_W'(ivx_q);
				mb = {1'b0, e_q};
			end
			ST_IVY: begin
				ma = MA_W'(ivy_q);
				mb = {1'b0, e_q};
			end
			ST_PX: begin
				ma = MA_W'(fvx_q);
				mb = {2'b00, dt_q};
			end
			ST_PY: begin
				ma = MA_W'(fvy_q);
				mb = {2'b00, dt_q};
			end
			ST_POSY: begin
				ma = MA_W'(alpha_diff);
				mb = {2'b00, t_q};
			end
			ST_ALPHA: begin
				ma = MA_W'(size_diff);
				mb = {2'b00, t_q};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign mul_p = ma * mb;

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	// Half-up rounded Q.16 product, used by the opacity and size blends.
	assign rnd_p = (prod_q + $signed(52'd32768)) >>> 16;

	// The divider starts once the new age is settled and runs while the
	// velocity update finishes.
	assign div_start = (st_q == ST_GVY);

	peu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (age_q),
		.den    (life_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_nx;
	end

	always_comb begin
		st_nx = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (func == FUNC_SPAWN || !active_q || age_nx >= life_q)
						st_nx = ST_DONE;
					else
						st_nx = ST_GVX;
				end
			end
			ST_GVX:   st_nx = ST_GVY;
			ST_GVY:   st_nx = ST_VELY;
			ST_VELY:  st_nx = ST_DIV;
			ST_DIV: begin
				if (div_done)
					st_nx = ease_on ? ST_SQ : ST_PX;
			end
			ST_SQ:    st_nx = cubic ? ST_CUBE : ST_EASE;
			ST_CUBE:  st_nx = ST_EASE;
			ST_EASE:  st_nx = ST_IVX;
			ST_IVX:   st_nx = ST_IVY;
			ST_IVY:   st_nx = ST_FVY;
			ST_FVY:   st_nx = ST_PX;
			ST_PX:    st_nx = ST_PY;
			ST_PY:    st_nx = ST_POSY;
			ST_POSY:  st_nx = ST_ALPHA;
			ST_ALPHA: st_nx = ST_SIZE;
			ST_SIZE:  st_nx = ST_DONE;
			ST_DONE: begin
				if (out_free)
					st_nx = ST_IDLE;
			end
			default:  st_nx = ST_IDLE;
		endcase
	end

	// Configuration, particle state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q        <= '0;
			gy_q        <= '0;
			life_q      <= 32'd65536;
			ab_q        <= 17'd65536;
			af_q        <= '0;
			sb_q        <= 24'd65536;
			sf_q        <= 24'd65536;
			mode_q      <= EASE_NONE;
			active_q    <= 1'b0;
			age_q       <= '0;
			timer_q     <= '0;
			frame_q     <= '0;
			velx_q      <= '0;
			vely_q      <= '0;
			ivx_q       <= '0;
			ivy_q       <= '0;
			posx_q      <= '0;
			posy_q      <= '0;
			alpha_q     <= 17'd65536;
			size_q      <= 24'd65536;
			dt_q        <= '0;
			t_q         <= '0;
			e_q         <= '0;
			fvx_q       <= '0;
			fvy_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GRAVITY_X:   gx_q   <= cfg_data;
					REG_GRAVITY_Y:   gy_q   <= cfg_data;
					REG_LIFE_SPAN:   life_q <= cfg_data;
					REG_ALPHA_BEGIN: ab_q   <= cfg_data[16:0];
					REG_ALPHA_FINAL: af_q   <= cfg_data[16:0];
					REG_SIZE_BEGIN:  sb_q   <= cfg_data[23:0];
					REG_SIZE_FINAL:  sf_q   <= cfg_data[23:0];
					REG_EASING_MODE: mode_q <= cfg_data[2:0];
					default: ;
				endcase
			end

			// A new result enters the output register as soon as it has room;
			// otherwise an accepted result leaves it.
			if (st_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						dt_q <= delta_time;
						if (func == FUNC_SPAWN) begin
							// Spawn keeps opacity and size from the previous life.
							posx_q   <= spawn_pos_x;
							posy_q   <= spawn_pos_y;
							velx_q   <= spawn_vel_x;
							vely_q   <= spawn_vel_y;
							ivx_q    <= spawn_vel_x;
							ivy_q    <= spawn_vel_y;
							age_q    <= '0;
							timer_q  <= '0;
							frame_q  <= '0;
							active_q <= 1'b1;
						end else if (active_q) begin
							age_q <= age_nx;
							if (age_nx >= life_q) begin
								active_q <= 1'b0;
							end else if (NUM_FRAMES != 0) begin
								if (timer_nx >= ANIM_PERIOD) begin
									timer_q <= '0;
									frame_q <= frame_nx;
								end else begin
									timer_q <= timer_nx;
								end
							end
						end
					end
				end
				ST_GVY:  velx_q <= sat_acc(velx_q, prod_q);
				ST_VELY: vely_q <= sat_acc(vely_q, prod_q);
				ST_DIV: begin
					if (div_done) begin
						t_q <= div_quot;
						// Without easing the position follows the new velocity.
						fvx_q <= velx_q;
						fvy_q <= vely_q;
					end
				end
				ST_EASE:  e_q    <= ease_fin(prod_q, mode_q, low);
				ST_IVY:   fvx_q  <= sat_acc(32'sd0, prod_q);
				ST_FVY:   fvy_q  <= sat_acc(32'sd0, prod_q);
				ST_PY:    posx_q <= sat_acc(posx_q, prod_q);
				ST_POSY:  posy_q <= sat_acc(posy_q, prod_q);
				ST_ALPHA: alpha_q <= ab_q + rnd_p[16:0];
				ST_SIZE:  size_q  <= sb_q + rnd_p[23:0];
				default: ;
			endcase
		end
	end

	// Result payload; loaded only when the output register is free.
	always_ff @(posedge clk) begin
		if (st_q == ST_DONE && out_free) begin
			alive_q  <= active_q;
			opx_q    <= posx_q;
			opy_q    <= posy_q;
			oalpha_q <= alpha_q;
			oscale_q <= size_q;
			oframe_q <= frame_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign alive       = alive_q;
	assign out_pos_x   = opx_q;
	assign out_pos_y   = opy_q;
	assign alpha_level = oalpha_q;
	assign scale       = oscale_q;
	assign frame_index = oframe_q;

`ifndef NO_ASSERTIONS
	// The divider only finishes while the sequencer waits for it.
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == ST_DIV))
		else $error("divider finished outside its wait state");

	// A finished result is held until the output register has room.
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE) && !out_free |=> (st_q == ST_DONE))
		else $error("result dropped while output register was full");

	// The animation frame stays within the frame count.
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		(NUM_FRAMES == 0) || (frame_q < NUM_FRAMES))
		else $error("animation frame out of range");
`endif

endmodule

// ===== dv/tb_particle_euler_update_with_easing_core.sv =====
// ----------------------------------------------------------------------------
// Particle Euler update testbench
// Drives spawn and tick requests with random gaps and result stalls, writes
// the configuration between phases, and checks every result field against a
// cycle-free predictor of the particle state kept in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_particle_euler_update_with_easing_core;
	import peu_pkg::*;

	typedef struct {
		logic        func;
		logic [15:0] dt;
		logic [31:0] px, py, vx, vy;
	} particle_req_t;

	typedef struct {
		logic        alive;
		logic [31:0] px, py;
		logic [16:0] alpha;
		logic [23:0] scale;
		logic [2:0]  frame;
	} particle_res_t;

	// Scoreboard: holds its own copy of the particle and the configuration and
	// queues the result each accepted request should produce.
	class particle_scoreboard;
		longint grav_x, grav_y, vel_x, vel_y, ivel_x, ivel_y, pos_x, pos_y;
		longint unsigned life, a_begin, a_final, s_begin, s_final, mode;
		longint unsigned age, anim, frame, alpha, size;
		bit active;
		particle_res_t pending_results[$];
		int mismatches;

		function new();
			grav_x = 0; grav_y = 0; life = 65536;
			a_begin = 65536; a_final = 0; s_begin = 65536; s_final = 65536; mode = 0;
			active = 0; age = 0; anim = 0; frame = 0; alpha = 65536; size = 65536;
			vel_x = 0; vel_y = 0; ivel_x = 0; ivel_y = 0; pos_x = 0; pos_y = 0;
			mismatches = 0;
		endfunction

		function void write_register(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_GRAVITY_X:   grav_x = longint'($signed(data));
				REG_GRAVITY_Y:   grav_y = longint'($signed(data));
				REG_LIFE_SPAN:   life = data;
				REG_ALPHA_BEGIN: a_begin = data[16:0];
				REG_ALPHA_FINAL: a_final = data[16:0];
				REG_SIZE_BEGIN:  s_begin = data[23:0];
				REG_SIZE_FINAL:  s_final = data[23:0];
				REG_EASING_MODE: mode = data[2:0];
				default: ;
			endcase
		endfunction

		// Round half up after a shift; an arithmetic shift floors negatives too.
		static function longint rnd(longint x, int s);
			longint y;
			y = x + (longint'(1) <<< (s - 1));
			return y >>> s;
		endfunction

		static function longint sat32(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		static function longint unsigned add_clamp(longint unsigned a, longint unsigned b);
			longint unsigned s;
			s = a + b;
			return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
		endfunction

		function longint eased(longint unsigned t);
			longint unsigned u, w;
			u = 65536 - t;
			w = 131072 - 2 * t;
			case (mode[2:0])
				EASE_QUAD_IN:     return (t * t + 32768) >> 16;
				EASE_QUAD_OUT:    return 65536 - ((u * u + 32768) >> 16);
				EASE_QUAD_INOUT:  return (t < 32768) ? ((2 * t * t + 32768) >> 16)
					: 65536 - ((w * w + 65536) >> 17);
				EASE_CUBIC_IN:    return (t * t * t + 64'h8000_0000) >> 32;
				EASE_CUBIC_OUT:   return 65536 - ((u * u * u + 64'h8000_0000) >> 32);
				EASE_CUBIC_INOUT: return (t < 32768) ? ((4 * t * t * t + 64'h8000_0000) >> 32)
					: 65536 - ((w * w * w + 64'h1_0000_0000) >> 33);
				default:          return 65536;
			endcase
		endfunction

		static function longint unsigned blend(longint unsigned a, longint unsigned b,
			longint unsigned t);
			return longint'(a) + rnd((longint'(b) - longint'(a)) * longint'(t), 16);
		endfunction

		function void advance(longint unsigned dt);
			longint unsigned t;
			longint fx, fy, e;
			if (!active) return;
			age = add_clamp(age, dt);
			if (age >= life) begin
				active = 0;
				return;
			end
			vel_x = sat32(vel_x + rnd(grav_x * longint'(dt), 16));
			vel_y = sat32(vel_y + rnd(grav_y * longint'(dt), 16));
			t = (age << 16) / life;
			fx = vel_x;
			fy = vel_y;
			if (mode >= 1 && mode <= 6) begin
				e = eased(t);
				fx = sat32(rnd(ivel_x * e, 16));
				fy = sat32(rnd(ivel_y * e, 16));
			end
			pos_x = sat32(pos_x + rnd(fx * longint'(dt), 16));
			pos_y = sat32(pos_y + rnd(fy * longint'(dt), 16));
			alpha = blend(a_begin, a_final, t) & 64'h1FFFF;
			size = blend(s_begin, s_final, t) & 64'hFF_FFFF;
			if (NUM_FRAMES != 0) begin
				anim = add_clamp(anim, dt);
				if (anim >= ANIM_PERIOD) begin
					anim = 0;
					frame = (frame + 1) % NUM_FRAMES;
				end
			end
		endfunction

		function void note_request(particle_req_t r);
			particle_res_t x;
			if (r.func == FUNC_SPAWN) begin
				pos_x = longint'($signed(r.px));
				pos_y = longint'($signed(r.py));
				vel_x = longint'($signed(r.vx));
				vel_y = longint'($signed(r.vy));
				ivel_x = vel_x;
				ivel_y = vel_y;
				age = 0;
				anim = 0;
				frame = 0;
				active = 1;
			end else begin
				advance(r.dt);
			end
			x.alive = active;
			x.px = pos_x[31:0];
			x.py = pos_y[31:0];
			x.alpha = alpha[16:0];
			x.scale = size[23:0];
			x.frame = frame[2:0];
			pending_results = {pending_results, x};
		endfunction

		function void report(string what, longint unsigned want, longint unsigned got);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0h, actual %0h", what, want, got);
		endfunction

		function void check_result(particle_res_t got);
			particle_res_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: result with no request outstanding");
				return;
			end
			want = pending_results.pop_front();
			if (got.alive !== want.alive) report("alive", want.alive, got.alive);
			if (got.px !== want.px) report("out_pos_x", want.px, got.px);
			if (got.py !== want.py) report("out_pos_y", want.py, got.py);
			if (got.alpha !== want.alpha) report("alpha_level", want.alpha, got.alpha);
			if (got.scale !== want.scale) report("scale", want.scale, got.scale);
			if (got.frame !== want.frame) report("frame_index", want.frame, got.frame);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               func;
	logic [15:0]        delta_time;
	logic signed [31:0] spawn_pos_x, spawn_pos_y, spawn_vel_x, spawn_vel_y;
	logic               out_valid;
	logic               out_stall;
	logic               alive;
	logic signed [31:0] out_pos_x, out_pos_y;
	logic [16:0]        alpha_level;
	logic [23:0]        scale;
	logic [2:0]         frame_index;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	particle_scoreboard sb;
	bit  steady;      // when set, neither side idles: back-to-back stretches
	int  stall_left;
	int  quiet_cycles;

	particle_euler_update_with_easing_core u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result side: after each accepted result the receiver stalls for a random
	// number of cycles, so stalls land on every phase of the update sequence.
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			out_stall = (stall_left > 0);
			if (stall_left > 0) stall_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			particle_res_t r;
			r.alive = alive;
			r.px = out_pos_x;
			r.py = out_pos_y;
			r.alpha = alpha_level;
			r.scale = scale;
			r.frame = frame_index;
			sb.check_result(r);
			stall_left = steady ? 0 : $urandom_range(0, 12);
		end
	end

	// Watchdog: if no channel completes a handshake before the quiet counter reaches
	// its limit, the block is taken to be hung and the test fails.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 5000) begin
			$display("status: fail");
			$finish;
		end
	end

	// Sends one request after a random gap and holds it until it is taken.
	task automatic send_request(particle_req_t r);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = r.func;
		delta_time = r.dt;
		spawn_pos_x = r.px;
		spawn_pos_y = r.py;
		spawn_vel_x = r.vx;
		spawn_vel_y = r.vy;
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note_request(r);
	endtask

	task automatic send_tick(logic [15:0] dt);
		particle_req_t r;
		r.func = FUNC_TICK;
		r.dt = dt;
		r.px = $urandom;
		r.py = $urandom;
		r.vx = $urandom;
		r.vy = $urandom;
		send_request(r);
	endtask

	task automatic send_spawn(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
		logic [31:0] vy);
		particle_req_t r;
		r.func = FUNC_SPAWN;
		r.dt = $urandom;
		r.px = px;
		r.py = py;
		r.vx = vx;
		r.vy = vy;
		send_request(r);
	endtask

	// Waits until every result is back, with the request line parked low.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		sb.write_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_all(logic [31:0] gx, logic [31:0] gy, logic [31:0] life,
		logic [31:0] ab, logic [31:0] af, logic [31:0] sbg, logic [31:0] sf, logic [2:0] m);
		write_reg(REG_GRAVITY_X, gx);
		write_reg(REG_GRAVITY_Y, gy);
		write_reg(REG_LIFE_SPAN, life);
		write_reg(REG_ALPHA_BEGIN, ab);
		write_reg(REG_ALPHA_FINAL, af);
		write_reg(REG_SIZE_BEGIN, sbg);
		write_reg(REG_SIZE_FINAL, sf);
		write_reg(REG_EASING_MODE, m);
	endtask

	// Random 32-bit value that is an extreme now and then.
	function automatic logic [31:0] wide_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] life;
		int n;
		sb = new();
		steady = 1'b0;
		quiet_cycles = 0;
		in_valid = 1'b0;
		func = FUNC_TICK;
		delta_time = '0;
		spawn_pos_x = '0;
		spawn_pos_y = '0;
		spawn_vel_x = '0;
		spawn_vel_y = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_GRAVITY_X;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at reset defaults: a tick while inactive reports the held
		// state, then a full life of one second from extreme spawn values, an
		// expiring tick, and a tick after expiry.
		send_tick(16'hFFFF);
		send_spawn(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_tick(16'h0000);
		send_tick(16'hFFFF);
		send_tick(16'h0001);
		send_tick(16'h1234);
		drain();

		// Extreme gravity pushes velocity and position into saturation, with the
		// opacity and size registers at the ends of their fields.
		write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h1FFFF,
			32'hFF_FFFF, 32'h0, EASE_NONE);
		send_spawn(32'h7FFF_0000, 32'h8000_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		repeat (4) send_tick(16'hFFFF);
		send_spawn(32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_tick(16'h8000);
		drain();

		// Lifetime of one unit: a zero step keeps the particle, any other ends it.
		write_all(32'h0, 32'h0, 32'h1, 32'h10000, 32'h0, 32'h10000, 32'h20000,
			EASE_CUBIC_INOUT);
		send_spawn(32'h100, 32'h200, 32'h10000, 32'hFFFF_0000);
		send_tick(16'h0000);
		send_tick(16'h0001);
		send_tick(16'h0001);
		drain();

		// Random phases: each phase a new setting, easing mode stepping through
		// every code including the unused one, then mostly spawn-and-tick lives.
		for (int p = 0; p < 16; p++) begin
			case (p % 4)
				0: life = $urandom_range(1, 300000);
				1: life = $urandom_range(1, 40000);
				2: life = 32'hFFFF_FFFF;
				default: life = $urandom;
			endcase
			write_all(wide_value(), wide_value(), life, $urandom_range(0, 65536),
				$urandom_range(0, 65536), $urandom & 32'hFF_FFFF, $urandom & 32'hFF_FFFF,
				3'(p % 8));
			steady = (p % 5 == 3);
			n = 0;
			while (n < 120) begin
				send_spawn(wide_value(), wide_value(), wide_value(), wide_value());
				n++;
				for (int k = $urandom_range(1, 20); k > 0; k--) begin
					if ($urandom_range(0, 9) == 0)
						send_tick($urandom);
					else
						send_tick($urandom_range(0, 12000));
					n++;
				end
				// Hold the sender off now and then until the block has caught up.
				if ($urandom_range(0, 7) == 0) drain();
			end
			drain();
		end

		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
